// ----- design/rgb_triplet_line_parser_core_macros.svh -----
// assertion macros for the rgb triplet line parser
`ifndef RGB_TRIPLET_LINE_PARSER_CORE_MACROS_SVH
`define RGB_TRIPLET_LINE_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define RTLP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtlp assertion failed");

`define RTLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtlp assertion failed");

`else

`define RTLP_ASSERT_SAME(label, clk, rst, ante, cons)

`define RTLP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/rtlp_pkg.sv -----
// shared types and constants of the rgb triplet line parser
package rtlp_pkg;

   localparam int LINE_CAP = 32;
   localparam int COUNT_WIDTH = $clog2(LINE_CAP);
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(LINE_CAP - 1);

   localparam int ACCUM_WIDTH = 9;
   localparam int PRODUCT_WIDTH = 12;
   localparam logic [ACCUM_WIDTH-1:0] ACCUM_SAT = 9'd256;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_VT    = 8'd11;
   localparam logic [7:0] CHAR_FF    = 8'd12;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   localparam logic [7:0] RED_RESET   = 8'd255;
   localparam logic [7:0] GREEN_RESET = 8'd0;
   localparam logic [7:0] BLUE_RESET  = 8'd255;

   typedef struct packed {
      logic       valid;
      logic       line_end;
      logic [7:0] rx_byte;
   } stage_type;

   typedef struct packed {
      logic       line_ok;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } result_type;

endpackage

// ----- design/rtlp_input_stage.sv -----
// input register holding one received byte and its line-end flag
module rtlp_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                advance,
   output rtlp_pkg::stage_type stage
);

   logic       valid_ff;
   logic       valid_in;
   logic       line_end_ff;
   logic       line_end_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       load;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in    = valid_ff;
      line_end_in = line_end_ff;
      byte_in     = byte_ff;
      if (load) begin
         valid_in    = 1'b1;
         byte_in     = req_rx_byte;
         line_end_in = (req_rx_byte == rtlp_pkg::CHAR_CR) ||
                       (req_rx_byte == rtlp_pkg::CHAR_LF);
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      line_end_ff <= line_end_in;
      byte_ff     <= byte_in;
   end

   assign stage.valid    = valid_ff;
   assign stage.line_end = line_end_ff;
   assign stage.rx_byte  = byte_ff;

endmodule

// ----- design/rtlp_parser.sv -----
// parse state and colour levels, updated once per byte
module rtlp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  rtlp_pkg::stage_type  stage,
   output rtlp_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGIT,
      PH_DONE,
      PH_FAIL
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [1:0]                             field_ff, field_in;
   logic [rtlp_pkg::COUNT_WIDTH-1:0]       count_ff, count_in;
   logic                                   ended_ff, ended_in;
   logic [rtlp_pkg::ACCUM_WIDTH-1:0]       accum_ff, accum_in;
   logic                                   negative_ff, negative_in;
   logic [7:0]                             parsed_red_ff, parsed_red_in;
   logic [7:0]                             parsed_green_ff, parsed_green_in;
   logic [7:0]                             red_ff, red_in;
   logic [7:0]                             green_ff, green_in;
   logic [7:0]                             blue_ff, blue_in;

   logic                                   is_digit;
   logic                                   is_space;
   logic [3:0]                             digit_value;
   logic [rtlp_pkg::PRODUCT_WIDTH-1:0]     product;
   logic [rtlp_pkg::ACCUM_WIDTH-1:0]       accum_next;
   logic                                   value_valid;
   logic                                   line_ok;
   logic [7:0]                             c;

   assign c           = stage.rx_byte;
   assign is_digit    = (c >= rtlp_pkg::CHAR_ZERO) && (c <= rtlp_pkg::CHAR_NINE);
   assign is_space    = (c == rtlp_pkg::CHAR_SPACE) || (c == rtlp_pkg::CHAR_TAB) ||
                        (c == rtlp_pkg::CHAR_VT) || (c == rtlp_pkg::CHAR_FF);
   assign digit_value = c[3:0];
   assign product     = ({{(rtlp_pkg::PRODUCT_WIDTH - rtlp_pkg::ACCUM_WIDTH){1'b0}}, accum_ff}
                         * rtlp_pkg::PRODUCT_WIDTH'(10))
                        + {{(rtlp_pkg::PRODUCT_WIDTH - 4){1'b0}}, digit_value};
   assign accum_next  = (product > rtlp_pkg::PRODUCT_WIDTH'(rtlp_pkg::ACCUM_SAT)) ?
                        rtlp_pkg::ACCUM_SAT : product[rtlp_pkg::ACCUM_WIDTH-1:0];
   assign value_valid = !accum_ff[rtlp_pkg::ACCUM_WIDTH-1] && !(negative_ff && (|accum_ff));
   assign line_ok     = (phase_ff == PH_DONE) ||
                        ((phase_ff == PH_DIGIT) && (field_ff == 2'd2) && value_valid);

   always_comb begin
      phase_in        = phase_ff;
      field_in        = field_ff;
      count_in        = count_ff;
      ended_in        = ended_ff;
      accum_in        = accum_ff;
      negative_in     = negative_ff;
      parsed_red_in   = parsed_red_ff;
      parsed_green_in = parsed_green_ff;
      red_in          = red_ff;
      green_in        = green_ff;
      blue_in         = blue_ff;
      if (advance) begin
         if (stage.line_end) begin
            if (line_ok) begin
               red_in   = parsed_red_ff;
               green_in = parsed_green_ff;
               blue_in  = accum_ff[7:0];
            end
            phase_in        = PH_SPACE;
            field_in        = 2'd0;
            count_in        = '0;
            ended_in        = 1'b0;
            accum_in        = '0;
            negative_in     = 1'b0;
            parsed_red_in   = 8'd0;
            parsed_green_in = 8'd0;
         end else if (count_ff != rtlp_pkg::COUNT_LIMIT) begin
            count_in = count_ff + 1'b1;
            if (c == rtlp_pkg::CHAR_NUL) begin
               ended_in = 1'b1;
            end else if (!ended_ff) begin
               case (phase_ff)
                  PH_SPACE: begin
                     if (is_space) begin
                        phase_in = PH_SPACE;
                     end else if ((c == rtlp_pkg::CHAR_PLUS) ||
                                  (c == rtlp_pkg::CHAR_MINUS)) begin
                        negative_in = (c == rtlp_pkg::CHAR_MINUS);
                        phase_in    = PH_SIGN;
                     end else if (is_digit) begin
                        accum_in = {{(rtlp_pkg::ACCUM_WIDTH - 4){1'b0}}, digit_value};
                        phase_in = PH_DIGIT;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_SIGN: begin
                     if (is_digit) begin
                        accum_in = {{(rtlp_pkg::ACCUM_WIDTH - 4){1'b0}}, digit_value};
                        phase_in = PH_DIGIT;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_DIGIT: begin
                     if (is_digit) begin
                        accum_in = accum_next;
                     end else if (field_ff == 2'd2) begin
                        phase_in = value_valid ? PH_DONE : PH_FAIL;
                     end else if ((c == rtlp_pkg::CHAR_MINUS) && value_valid) begin
                        if (field_ff == 2'd0) begin
                           parsed_red_in = accum_ff[7:0];
                        end else begin
                           parsed_green_in = accum_ff[7:0];
                        end
                        field_in    = field_ff + 2'd1;
                        accum_in    = '0;
                        negative_in = 1'b0;
                        phase_in    = PH_SPACE;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SPACE;
         field_ff        <= 2'd0;
         count_ff        <= '0;
         ended_ff        <= 1'b0;
         accum_ff        <= '0;
         negative_ff     <= 1'b0;
         parsed_red_ff   <= 8'd0;
         parsed_green_ff <= 8'd0;
         red_ff          <= rtlp_pkg::RED_RESET;
         green_ff        <= rtlp_pkg::GREEN_RESET;
         blue_ff         <= rtlp_pkg::BLUE_RESET;
      end else begin
         phase_ff        <= phase_in;
         field_ff        <= field_in;
         count_ff        <= count_in;
         ended_ff        <= ended_in;
         accum_ff        <= accum_in;
         negative_ff     <= negative_in;
         parsed_red_ff   <= parsed_red_in;
         parsed_green_ff <= parsed_green_in;
         red_ff          <= red_in;
         green_ff        <= green_in;
         blue_ff         <= blue_in;
      end
   end

   assign result.line_ok = line_ok;
   assign result.red     = red_in;
   assign result.green   = green_in;
   assign result.blue    = blue_in;

endmodule

// ----- design/rgb_triplet_line_parser_core.sv -----
// rgb triplet line parser: reads "R-G-B" text lines byte by byte and reports the colour per line
// One byte is taken per cycle, back to back, save when input is held back as told below. Each byte
// waits in the input register and then enters the parse state; a line end also loads the result
// register. A CR or LF byte gives one result (line_ok and the colour in force after the line),
// which appears on the rsp_ channel the cycle after the line-end byte is processed; other bytes
// give none. Input is only held back when a line-end byte meets a result that has not yet been
// taken. The colour starts at red 255, green 0, blue 255 after reset.
`include "rgb_triplet_line_parser_core_macros.svh"

module rgb_triplet_line_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_ok,
   output logic [7:0] rsp_red_duty,
   output logic [7:0] rsp_green_duty,
   output logic [7:0] rsp_blue_duty
);

   rtlp_pkg::stage_type  stage;
   rtlp_pkg::result_type result;
   logic                 advance;
   logic                 emit;

   logic                 rsp_valid_ff, rsp_valid_in;
   rtlp_pkg::result_type rsp_data_ff, rsp_data_in;

   assign advance = stage.valid && (!stage.line_end || !rsp_valid_ff || rsp_ready);
   assign emit    = advance && stage.line_end;

   rtlp_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .stage       (stage)
   );

   rtlp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .stage   (stage),
      .result  (result)
   );

   // result register, loaded on each line end
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_ok    = rsp_data_ff.line_ok;
   assign rsp_red_duty   = rsp_data_ff.red;
   assign rsp_green_duty = rsp_data_ff.green;
   assign rsp_blue_duty  = rsp_data_ff.blue;

   // a processed line end always leaves a result waiting
   `RTLP_ASSERT_NEXT(a_line_end_gives_result, clock, reset, emit, rsp_valid_ff)
   // bytes other than line ends never stall in the input register
   `RTLP_ASSERT_SAME(a_plain_byte_flows, clock, reset, stage.valid && !stage.line_end, advance)
   // a result appears only after a line end was processed
   `RTLP_ASSERT_SAME(a_result_has_cause, clock, reset,
                     rsp_valid_ff && !$past(rsp_valid_ff), $past(emit))

endmodule

// ----- bench/rgb_triplet_line_parser_core_tb.sv -----
// self-checking testbench for the rgb triplet line parser core
`timescale 1ns / 100ps

module rgb_triplet_line_parser_core_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BYTES = 900;

   typedef enum logic [2:0] {
      SKIP_SPACE,
      SIGN_SEEN,
      IN_DIGITS,
      TRIPLET_DONE,
      LINE_BAD
   } line_phase_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_line_ok;
   logic [7:0] rsp_red_duty;
   logic [7:0] rsp_green_duty;
   logic [7:0] rsp_blue_duty;

   line_phase_type line_phase;
   int          field_no;
   int          char_count;
   bit          text_cut;
   int          accum_value;
   bit          minus_seen;
   logic [7:0]  red_seen, green_seen;
   logic [7:0]  red_now, green_now, blue_now;

   rtlp_pkg::result_type colour_due[$];
   logic [7:0]  line_bytes[$];
   int          failures = 0;
   int          bytes_sent = 0;
   int          cycle_count = 0;
   bit          steady_flow = 1'b0;
   int unsigned hold_request = 0;

   rgb_triplet_line_parser_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_ok   (rsp_line_ok),
      .rsp_red_duty  (rsp_red_duty),
      .rsp_green_duty(rsp_green_duty),
      .rsp_blue_duty (rsp_blue_duty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parse state and colour model

   function automatic void clear_line();
      line_phase = SKIP_SPACE;
      field_no = 0;
      char_count = 0;
      text_cut = 1'b0;
      accum_value = 0;
      minus_seen = 1'b0;
      red_seen = 8'd0;
      green_seen = 8'd0;
   endfunction

   function automatic bit field_fits();
      return accum_value <= 255 && !(minus_seen && accum_value != 0);
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      bit is_digit;
      int next_value;
      is_digit = c >= rtlp_pkg::CHAR_ZERO && c <= rtlp_pkg::CHAR_NINE;
      case (line_phase)
         SKIP_SPACE: begin
            if (c == rtlp_pkg::CHAR_SPACE || c == rtlp_pkg::CHAR_TAB ||
                c == rtlp_pkg::CHAR_VT || c == rtlp_pkg::CHAR_FF) begin
            end else if (c == rtlp_pkg::CHAR_PLUS || c == rtlp_pkg::CHAR_MINUS) begin
               minus_seen = c == rtlp_pkg::CHAR_MINUS;
               line_phase = SIGN_SEEN;
            end else if (is_digit) begin
               accum_value = int'(c - rtlp_pkg::CHAR_ZERO);
               line_phase = IN_DIGITS;
            end else begin
               line_phase = LINE_BAD;
            end
         end
         SIGN_SEEN: begin
            if (is_digit) begin
               accum_value = int'(c - rtlp_pkg::CHAR_ZERO);
               line_phase = IN_DIGITS;
            end else begin
               line_phase = LINE_BAD;
            end
         end
         IN_DIGITS: begin
            if (is_digit) begin
               next_value = accum_value * 10 + int'(c - rtlp_pkg::CHAR_ZERO);
               accum_value = next_value > 256 ? 256 : next_value;
            end else if (field_no >= 2) begin
               line_phase = field_fits() ? TRIPLET_DONE : LINE_BAD;
            end else if (c == rtlp_pkg::CHAR_MINUS && field_fits()) begin
               if (field_no == 0) red_seen = accum_value[7:0];
               else green_seen = accum_value[7:0];
               field_no++;
               accum_value = 0;
               minus_seen = 1'b0;
               line_phase = SKIP_SPACE;
            end else begin
               line_phase = LINE_BAD;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] c);
      rtlp_pkg::result_type due;
      bit ok;
      if (c == rtlp_pkg::CHAR_CR || c == rtlp_pkg::CHAR_LF) begin
         ok = line_phase == TRIPLET_DONE ||
              (line_phase == IN_DIGITS && field_no >= 2 && field_fits());
         if (ok) begin
            red_now = red_seen;
            green_now = green_seen;
            blue_now = accum_value[7:0];
         end
         due.line_ok = ok;
         due.red = red_now;
         due.green = green_now;
         due.blue = blue_now;
         colour_due.push_back(due);
         clear_line();
      end else if (char_count < rtlp_pkg::LINE_CAP - 1) begin
         char_count++;
         if (c == rtlp_pkg::CHAR_NUL) text_cut = 1'b1;
         else if (!text_cut) scan_char(c);
      end
   endfunction

   // sender

   task automatic send_byte(input logic [7:0] c);
      @(negedge clock);
      while (!steady_flow && $urandom_range(0, 99) < 15) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = c;
      do @(posedge clock); while (!req_ready);
      predict_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_spaces(input int n);
      repeat (n) send_byte(rtlp_pkg::CHAR_SPACE);
   endtask

   // receiver, with an optional long hold-off

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = steady_flow || $urandom_range(0, 99) >= 15;
         end
      end
   end

   // result checker

   function automatic void check_field(input string name, input int due, input int seen);
      if (due != seen) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, due, seen);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rtlp_pkg::result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (colour_due.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual ok %0b rgb %0d %0d %0d",
                     $time, rsp_line_ok, rsp_red_duty, rsp_green_duty, rsp_blue_duty);
            failures++;
         end else begin
            due = colour_due.pop_front();
            check_field("line_ok", due.line_ok, rsp_line_ok);
            check_field("red_duty", due.red, rsp_red_duty);
            check_field("green_duty", due.green, rsp_green_duty);
            check_field("blue_duty", due.blue, rsp_blue_duty);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // random line builder

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic push_blanks(input int n);
      logic [7:0] blank_set[4];
      blank_set = '{rtlp_pkg::CHAR_SPACE, rtlp_pkg::CHAR_TAB, rtlp_pkg::CHAR_VT,
                    rtlp_pkg::CHAR_FF};
      repeat (n) line_bytes.push_back(blank_set[$urandom_range(0, 3)]);
   endtask

   task automatic push_number();
      int unsigned pick;
      int unsigned value;
      pick = $urandom_range(0, 99);
      if (pick < 10) value = $urandom_range(256, 99999);
      else if (pick < 15) value = 0;
      else if (pick < 20) value = 255;
      else value = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) push_text("0");
      push_text($sformatf("%0d", value));
   endtask

   task automatic build_triplet();
      int unsigned pick;
      for (int f = 0; f < 3; f++) begin
         if ($urandom_range(0, 99) < 30) push_blanks($urandom_range(1, 3));
         pick = $urandom_range(0, 99);
         if (pick < 8) line_bytes.push_back(rtlp_pkg::CHAR_PLUS);
         else if (pick < 14) line_bytes.push_back(rtlp_pkg::CHAR_MINUS);
         push_number();
         if (f < 2) line_bytes.push_back(rtlp_pkg::CHAR_MINUS);
      end
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(32, 126)));
      end
   endtask

   task automatic spoil_line();
      int unsigned pick;
      int at;
      if (line_bytes.size() == 0) return;
      pick = $urandom_range(0, 99);
      at = $urandom_range(0, line_bytes.size() - 1);
      if (pick < 8) line_bytes[at] = 8'($urandom_range(0, 255));
      else if (pick < 12) line_bytes.delete(at);
      else if (pick < 16) line_bytes.insert(at, rtlp_pkg::CHAR_NUL);
   endtask

   task automatic push_line_end();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) line_bytes.push_back(rtlp_pkg::CHAR_LF);
      else if (pick < 80) line_bytes.push_back(rtlp_pkg::CHAR_CR);
      else begin
         line_bytes.push_back(rtlp_pkg::CHAR_CR);
         line_bytes.push_back(rtlp_pkg::CHAR_LF);
      end
   endtask

   task automatic send_line();
      while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
   endtask

   // tests

   task automatic test_reset_colour();
      send_text("\n");
   endtask

   task automatic test_valid_lines();
      send_text("0-0-0\r\n");
      send_text("255-255-255\n");
      send_text("+7- -0-\t09\r");
      send_text("1-");
      send_byte(rtlp_pkg::CHAR_VT);
      send_byte(rtlp_pkg::CHAR_FF);
      send_text("2-3 trailing\n");
   endtask

   task automatic test_format_errors();
      send_text("1--2-3\n");
      send_text("256-0-0\n");
      send_text("1-2-999999\n");
      send_text("1-2-+\n");
      send_text("1 -2-3\n");
      send_text("1-2\n");
      send_text("x\n");
   endtask

   task automatic test_nul_and_long_line();
      send_text("4-5");
      send_byte(rtlp_pkg::CHAR_NUL);
      send_text("-6\n");
      send_text("4-5-6");
      send_byte(rtlp_pkg::CHAR_NUL);
      send_text("zz\n");
      send_spaces(26);
      send_text("9-8-7\n");
      send_spaces(27);
      send_text("9-8-7\n");
   endtask

   task automatic test_random_lines();
      int unsigned pick;
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         steady_flow = bytes_sent < stop_at - RANDOM_BYTES + 250;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            build_triplet();
            spoil_line();
         end else if (pick < 85) begin
            push_blanks($urandom_range(8, 28));
            build_triplet();
         end else begin
            repeat ($urandom_range(0, 40)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
         push_line_end();
         send_line();
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_back_pressure();
      hold_request = 400;
      repeat (20) send_text("12-34-56\n");
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'd0;
      red_now = rtlp_pkg::RED_RESET;
      green_now = rtlp_pkg::GREEN_RESET;
      blue_now = rtlp_pkg::BLUE_RESET;
      clear_line();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_colour();
      test_valid_lines();
      test_format_errors();
      test_nul_and_long_line();
      test_back_pressure();
      test_random_lines();

      @(negedge clock);
      req_valid = 1'b0;
      while (colour_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
